### rtl/line_pixel_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_defines
// Assertion macros used by the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types, constants and pixel formatting helpers for the line rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int unsigned LprWidth    = 32;
    localparam int unsigned LprHeight   = 16;
    localparam int unsigned RowsPerWord = 4;
    localparam int unsigned WordsPerCol = LprHeight / RowsPerWord;

    localparam logic [3:0] MaskTop = 4'b1000;

    typedef logic [4:0] coord_x_t;
    typedef logic [3:0] coord_y_t;
    typedef logic [6:0] err_t;
    typedef logic [4:0] delta_t;
    typedef logic [5:0] count_t;
    typedef logic [6:0] word_t;
    typedef logic [3:0] mask_t;

    typedef struct packed {
        logic x_major;
        logic x_dec;
        logic y_dec;
    } step_flags_t;

    typedef struct packed {
        coord_x_t x;
        coord_y_t y;
        err_t     err;
    } walk_t;

    function automatic coord_x_t clamp_x(input coord_x_t v);
        if (int'(v) > int'(LprWidth) - 1)
            return coord_x_t'(LprWidth - 1);
        return v;
    endfunction

    function automatic coord_y_t clamp_y(input coord_y_t v);
        if (int'(v) > int'(LprHeight) - 1)
            return coord_y_t'(LprHeight - 1);
        return v;
    endfunction

    function automatic word_t word_index_of(input coord_x_t px, input coord_y_t py);
        return word_t'(int'(px) * int'(WordsPerCol) + int'(py[3:2]));
    endfunction

    function automatic mask_t row_mask_of(input coord_y_t py);
        return MaskTop >> py[1:0];
    endfunction

endpackage

### rtl/line_pixel_rasterizer.sv
// An accepted line item loads the walk registers and moves the sequencer to
// ST_RUN, which then registers each pixel into the output register. Throughput:
// one pixel per cycle while out_stall is low; the step unit runs once per pixel
// and the next line is taken once the last pixel has left the stepper.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line stepper emitting one pixel item per cycle, unless the receiver stalls, with address data.
// ----------------------------------------------------------------------------
`include "line_pixel_rasterizer_defines.svh"

module line_pixel_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lpr_pkg::coord_x_t  start_x,
    input  lpr_pkg::coord_y_t  start_y,
    input  lpr_pkg::coord_x_t  end_x,
    input  lpr_pkg::coord_y_t  end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output lpr_pkg::coord_x_t  pix_x,
    output lpr_pkg::coord_y_t  pix_y,
    output lpr_pkg::word_t     word_index,
    output lpr_pkg::mask_t     row_mask,
    output logic               last_pixel
);
    import lpr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t      state_reg,     state_next;
    walk_t       walk_reg,      walk_next;
    step_flags_t flags_reg,     flags_next;
    delta_t      major_reg,     major_next;
    delta_t      minor_reg,     minor_next;
    count_t      left_reg,      left_next;
    logic        out_valid_reg, out_valid_next;
    coord_x_t    pix_x_reg,     pix_x_next;
    coord_y_t    pix_y_reg,     pix_y_next;
    word_t       word_reg,      word_next;
    mask_t       mask_reg,      mask_next;
    logic        last_reg,      last_next;

    coord_x_t x0, x1;
    coord_y_t y0, y1;
    delta_t   dx, dy;
    logic     x_major;
    logic     in_accept;
    logic     pix_load;
    walk_t    walk_step;

    lpr_step_unit u_step (
        .cur   (walk_reg),
        .flags (flags_reg),
        .major (major_reg),
        .minor (minor_reg),
        .nxt   (walk_step)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // advance when the output register is free or being drained
    assign pix_load  = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        x0 = clamp_x(start_x);
        y0 = clamp_y(start_y);
        x1 = clamp_x(end_x);
        y1 = clamp_y(end_y);
        dx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
        dy = (y1 >= y0) ? delta_t'(y1 - y0) : delta_t'(y0 - y1);
        x_major = (dx >= dy);
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        flags_next     = flags_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        word_next      = word_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    flags_next.x_major = x_major;
                    flags_next.x_dec   = (x1 < x0);
                    flags_next.y_dec   = (y1 < y0);
                    major_next         = x_major ? dx : dy;
                    minor_next         = x_major ? dy : dx;
                    walk_next.x        = x0;
                    walk_next.y        = y0;
                    walk_next.err      = {2'b00, major_next >> 1};
                    left_next          = {1'b0, major_next} + 6'd1;
                    state_next         = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pix_load)
                begin
                    out_valid_next = 1'b1;
                    pix_x_next     = walk_reg.x;
                    pix_y_next     = walk_reg.y;
                    word_next      = word_index_of(walk_reg.x, walk_reg.y);
                    mask_next      = row_mask_of(walk_reg.y);
                    last_next      = (left_reg == 6'd1);
                    walk_next      = walk_step;
                    left_next      = left_reg - 6'd1;
                    if (left_reg == 6'd1)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_reg      <= '0;
            flags_reg     <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            pix_x_reg     <= '0;
            pix_y_reg     <= '0;
            word_reg      <= '0;
            mask_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            flags_reg     <= flags_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            pix_x_reg     <= pix_x_next;
            pix_y_reg     <= pix_y_next;
            word_reg      <= word_next;
            mask_reg      <= mask_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pix_x      = pix_x_reg;
    assign pix_y      = pix_y_reg;
    assign word_index = word_reg;
    assign row_mask   = mask_reg;
    assign last_pixel = last_reg;

    `LPR_ASSERT_NOW(a_run_has_pixels, state_reg == ST_RUN, left_reg != 6'd0, "stepper running with no pixels left")
    `LPR_ASSERT_NEXT(a_last_ends_line, pix_load && left_reg == 6'd1, state_reg == ST_IDLE && last_pixel, "last pixel did not end the line")
    `LPR_ASSERT_NOW(a_mask_onehot, out_valid, $onehot(row_mask), "row mask not one-hot")
    `LPR_ASSERT_NOW(a_word_matches_y, out_valid, word_index[1:0] == pix_y[3:2], "word index disagrees with row")

endmodule

### rtl/lpr_step_unit.sv
// ----------------------------------------------------------------------------
// lpr_step_unit
// Shared Bresenham step: error add, compare and subtract, coordinate advance.
// ----------------------------------------------------------------------------
module lpr_step_unit (
    input  lpr_pkg::walk_t       cur,
    input  lpr_pkg::step_flags_t flags,
    input  lpr_pkg::delta_t      major,
    input  lpr_pkg::delta_t      minor,
    output lpr_pkg::walk_t       nxt
);
    import lpr_pkg::*;

    err_t sum;
    logic minor_step;

    always_comb
    begin
        sum        = cur.err + {2'b00, minor};
        minor_step = (sum >= {2'b00, major});
        nxt.err    = minor_step ? (sum - {2'b00, major}) : sum;

        nxt.x = cur.x;
        if (flags.x_major || minor_step)
            nxt.x = flags.x_dec ? (cur.x - 5'd1) : (cur.x + 5'd1);

        nxt.y = cur.y;
        if (!flags.x_major || minor_step)
            nxt.y = flags.y_dec ? (cur.y - 4'd1) : (cur.y + 4'd1);
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bresenham line rasterizer. Each accepted line
// is expanded into its expected pixel items by a local stepper, and every
// pixel the block emits is checked field by field against the oldest one.
// Directed lines cover the extremes, seven of the eight octants and single points; random
// lines follow under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import lpr_pkg::*;

    typedef struct {
        coord_x_t x;
        coord_y_t y;
        word_t    word;
        mask_t    mask;
        logic     last;
    } pixel_t;

    localparam int MaxPixels = 32;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    coord_x_t start_x = '0;
    coord_y_t start_y = '0;
    coord_x_t end_x = '0;
    coord_y_t end_y = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    coord_x_t pix_x;
    coord_y_t pix_y;
    word_t    word_index;
    mask_t    row_mask;
    logic     last_pixel;

    pixel_t pending_pixels[$];
    int     fail_count = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;

    line_pixel_rasterizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .word_index (word_index),
        .row_mask   (row_mask),
        .last_pixel (last_pixel)
    );

    always #10 clk = ~clk;

    // Walk the line from start to end and queue one pixel per step
    function automatic void plot_line(input coord_x_t sx, input coord_y_t sy,
                                      input coord_x_t ex, input coord_y_t ey);
        int     x0, y0, x1, y1;
        int     dx, dy, major, minor, err, cx, cy, count;
        bit     x_major, x_dec, y_dec, minor_step;
        pixel_t p;
        x0 = (int'(sx) > int'(LprWidth) - 1) ? int'(LprWidth) - 1 : int'(sx);
        y0 = (int'(sy) > int'(LprHeight) - 1) ? int'(LprHeight) - 1 : int'(sy);
        x1 = (int'(ex) > int'(LprWidth) - 1) ? int'(LprWidth) - 1 : int'(ex);
        y1 = (int'(ey) > int'(LprHeight) - 1) ? int'(LprHeight) - 1 : int'(ey);
        dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
        x_major = (dx >= dy);
        x_dec = (x1 < x0);
        y_dec = (y1 < y0);
        major = x_major ? dx : dy;
        minor = x_major ? dy : dx;
        err = major / 2;
        count = major + 1;
        cx = x0;
        cy = y0;
        for (int i = 0; i < count && i < MaxPixels; i++)
        begin
            p.x    = coord_x_t'(cx);
            p.y    = coord_y_t'(cy);
            p.word = word_t'(cx * int'(LprHeight / RowsPerWord) + cy / 4);
            p.mask = mask_t'(8 >> (cy % 4));
            p.last = (i == count - 1);
            pending_pixels.push_back(p);
            err = (err + minor) & 127;
            minor_step = (err >= major);
            if (minor_step)
                err = (err - major) & 127;
            if (x_major || minor_step)
                cx = (x_dec ? cx - 1 : cx + 1) & 31;
            if (!x_major || minor_step)
                cy = (y_dec ? cy - 1 : cy + 1) & 15;
        end
    endfunction

    // Present one line item and hold it until the block takes it
    task automatic draw_line(input int sx, input int sy, input int ex, input int ey);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= coord_x_t'(sx);
        start_y  <= coord_y_t'(sy);
        end_x    <= coord_x_t'(ex);
        end_y    <= coord_y_t'(ey);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        plot_line(coord_x_t'(sx), coord_y_t'(sy), coord_x_t'(ex), coord_y_t'(ey));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Check each pixel item against the oldest expectation
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d", pix_x, pix_y);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_x !== want.x)
                begin
                    $error("pix_x: expected %0d, got %0d", want.x, pix_x);
                    fail_count++;
                end
                if (pix_y !== want.y)
                begin
                    $error("pix_y: expected %0d, got %0d", want.y, pix_y);
                    fail_count++;
                end
                if (word_index !== want.word)
                begin
                    $error("word_index: expected %0d, got %0d", want.word, word_index);
                    fail_count++;
                end
                if (row_mask !== want.mask)
                begin
                    $error("row_mask: expected %0d, got %0d", want.mask, row_mask);
                    fail_count++;
                end
                if (last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
                    fail_count++;
                end
            end
        end
    end

    // Extremes, seven of the eight octants, axis lines, diagonals and single points
    task automatic test_directed_lines();
        draw_line(0, 0, 0, 0);
        draw_line(31, 15, 31, 15);
        draw_line(0, 0, 31, 0);
        draw_line(31, 15, 0, 15);
        draw_line(0, 0, 0, 15);
        draw_line(31, 15, 31, 0);
        draw_line(0, 0, 15, 15);
        draw_line(15, 15, 0, 0);
        draw_line(31, 0, 16, 15);
        draw_line(0, 15, 31, 0);
        draw_line(31, 0, 0, 15);
        draw_line(3, 0, 10, 15);
        draw_line(10, 15, 3, 0);
        draw_line(20, 2, 18, 13);
        draw_line(5, 7, 6, 8);
        draw_line(7, 9, 8, 9);
        draw_line(12, 4, 12, 5);
        draw_line(0, 0, 31, 15);
        draw_line(31, 15, 0, 0);
        draw_line(30, 14, 1, 1);
    endtask

    task automatic test_random_lines(input int items);
        int sx, sy, ex, ey, pick;
        for (int i = 0; i < items; i++)
        begin
            sx = $urandom_range(31);
            sy = $urandom_range(15);
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                ex = $urandom_range(31);
                ey = $urandom_range(15);
            end
            else if (pick < 85)
            begin
                // short line around the start point
                ex = sx + $urandom_range(6) - 3;
                ey = sy + $urandom_range(6) - 3;
                ex = (ex < 0) ? 0 : (ex > 31) ? 31 : ex;
                ey = (ey < 0) ? 0 : (ey > 15) ? 15 : ey;
            end
            else if (pick < 92)
            begin
                ex = $urandom_range(31);
                ey = sy;
            end
            else
            begin
                ex = sx;
                ey = $urandom_range(15);
            end
            draw_line(sx, sy, ex, ey);
        end
    endtask

    // Hold the sender until every queued pixel has come out, then resume
    task automatic test_drain_pause();
        test_random_lines(20);
        wait_drained();
        test_random_lines(20);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 17;
        sink_stall_pct = 65;
        test_directed_lines();
        test_drain_pause();
        test_random_lines(74);

        src_idle_pct = 65;
        sink_stall_pct = 17;
        test_random_lines(114);

        src_idle_pct = 0;
        sink_stall_pct = 0;
        test_random_lines(114);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("line_pixel_rasterizer: match");
        else
            $display("line_pixel_rasterizer: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("line_pixel_rasterizer: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_step_unit.sv
rtl/line_pixel_rasterizer.sv
test/tb_top.sv
